// ----- src/dcsf_pkg.sv -----
package dcsf_pkg;

    // Sequencer states, one-hot
    typedef enum logic [10:0] {
        ST_IDLE  = 11'b00000000001,
        ST_SINA  = 11'b00000000010,
        ST_SINB  = 11'b00000000100,
        ST_SINP  = 11'b00000001000,
        ST_DLYA  = 11'b00000010000,
        ST_DLYB  = 11'b00000100000,
        ST_RD    = 11'b00001000000,
        ST_TAPA  = 11'b00010000000,
        ST_TAPB  = 11'b00100000000,
        ST_MIX   = 11'b01000000000,
        ST_WR    = 11'b10000000000
    } state_t;

    localparam int unsigned CFG_LFO_STEP   = 0;
    localparam int unsigned CFG_PAN_STEP   = 1;
    localparam int unsigned CFG_DEPTH      = 2;
    localparam int unsigned CFG_FEEDBACK   = 3;
    localparam int unsigned CFG_PAN_WIDTH  = 4;
    localparam int unsigned CFG_BASE_DELAY = 5;
    localparam int unsigned CFG_SWEEP_SPAN = 6;
    localparam int unsigned CFG_NUM_REGS   = 7;

    localparam logic [23:0] PHASE_B_RESET = 24'd2796203;

    function automatic logic signed [63:0] floor_shr(input logic signed [63:0] v,
                                                     input int unsigned s);
        floor_shr = v >>> s;
    endfunction

endpackage

// ----- src/dcsf_sine.sv -----
// Sine table: round(2^15*sin(2*pi*i/N)), clamped to 32767, built at elaboration
// with the quarter-wave fixed-point series.
module dcsf_sine #(
    parameter int SINE_ENTRIES = 1024
) (
    input  logic                              aclk,
    input  logic [$clog2(SINE_ENTRIES)-1:0]   idx,
    output logic signed [15:0]                sin_q15
);
    localparam int IW = $clog2(SINE_ENTRIES);

    function automatic logic signed [15:0] calc(input int unsigned i);
        logic [63:0] turn, r, x, x2, t, s;
        logic [1:0]  quad;
        begin
            turn = 64'(i) << (32 - IW);
            quad = turn[31:30];
            r    = turn & 64'h3FFF_FFFF;
            if (quad[0]) r = 64'h4000_0000 - r;
            x  = (r * 64'd1686629713) >> 30;
            x2 = (x * x) >> 30;
            t  = 64'h4000_0000;
            t  = 64'h4000_0000 - ((x2 * t) >> 30) / 64'd110;
            t  = 64'h4000_0000 - ((x2 * t) >> 30) / 64'd72;
            t  = 64'h4000_0000 - ((x2 * t) >> 30) / 64'd42;
            t  = 64'h4000_0000 - ((x2 * t) >> 30) / 64'd20;
            t  = 64'h4000_0000 - ((x2 * t) >> 30) / 64'd6;
            s = (x * t) >> 30;
            s = (s + 64'd16384) >> 15;
            if (s > 64'd32767) s = 64'd32767;
            calc = quad[1] ? -16'(s) : 16'(s);
        end
    endfunction

    logic signed [15:0] rom [SINE_ENTRIES];

    for (genvar g = 0; g < SINE_ENTRIES; g++) begin : g_rom
        localparam logic signed [15:0] ENTRY = calc(g);
        assign rom[g] = ENTRY;
    end

    always_ff @(posedge aclk) begin
        sin_q15 <= rom[idx];
    end
endmodule

// ----- src/dcsf_mac.sv -----
// Shared multiply unit: signed 25x18 product, registered.
module dcsf_mac (
    input  logic               aclk,
    input  logic signed [24:0] op_a,
    input  logic signed [17:0] op_b,
    output logic signed [42:0] prod
);
    always_ff @(posedge aclk) begin
        prod <= op_a * op_b;
    end
endmodule

// ----- src/dual_comb_stereo_flanger.sv -----
// Stereo dual-comb flanger with sine auto-pan.
//
// Input stream: one stereo frame per transfer (s_axis_tdata = left, right),
// s_axis_tlast marks the last frame of a block and is passed to m_axis_tlast.
// Output stream: one result frame per input frame, same order.
// Configuration: cfg_we/cfg_addr/cfg_wdata write one register per cycle; write
// only while the block is idle.
//
// Each frame is worked by a sequencer around one shared 25x18 multiplier and
// one sine table read port: three sine look-ups, one pan gain product, four
// delay products, four tap interpolation products, four pan products and two
// feedback products. s_axis_tready is high only while the sequencer idles and
// the output register is empty or drained in the same cycle, so a new frame is
// taken only once the previous one has been worked through. The delay lines
// are on-chip memories with one registered read port each.
// After reset the lines are cleared by a pass over all DELAY_DEPTH entries (one
// entry per cycle) during which no frame is taken. A stalled receiver holds the
// result in the output register and blocks the next frame.
module dual_comb_stereo_flanger #(
    parameter int DELAY_DEPTH  = 1024,
    parameter int SINE_ENTRIES = 1024
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,   // [15:0] left_in, [31:16] right_in
    input  logic        s_axis_tlast,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata,   // [15:0] left_out, [31:16] right_out
    output logic        m_axis_tlast,
    input  logic        cfg_we,
    input  logic [2:0]  cfg_addr,
    input  logic [15:0] cfg_wdata
);
    localparam int AW = $clog2(DELAY_DEPTH);
    localparam int IW = $clog2(SINE_ENTRIES);
    localparam logic [AW+7:0] DMAX = {AW+8{1'b1}};   // DELAY_DEPTH*256-1

    // configuration registers
    logic [15:0] lfo_step_reg, pan_step_reg, depth_reg, pan_width_reg;
    logic [14:0] feedback_reg;
    logic [8:0]  base_delay_reg, sweep_span_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            lfo_step_reg <= 16'd350; pan_step_reg <= 16'd350;
            depth_reg <= 16'd16384; feedback_reg <= 15'd16384;
            pan_width_reg <= 16'd16384; base_delay_reg <= 9'd48;
            sweep_span_reg <= 9'd192;
        end else if (cfg_we) begin
            unique case (cfg_addr)
                3'(dcsf_pkg::CFG_LFO_STEP):   lfo_step_reg   <= cfg_wdata;
                3'(dcsf_pkg::CFG_PAN_STEP):   pan_step_reg   <= cfg_wdata;
                3'(dcsf_pkg::CFG_DEPTH):      depth_reg      <= cfg_wdata;
                3'(dcsf_pkg::CFG_FEEDBACK):   feedback_reg   <= cfg_wdata[14:0];
                3'(dcsf_pkg::CFG_PAN_WIDTH):  pan_width_reg  <= cfg_wdata;
                3'(dcsf_pkg::CFG_BASE_DELAY): base_delay_reg <= cfg_wdata[8:0];
                3'(dcsf_pkg::CFG_SWEEP_SPAN): sweep_span_reg <= cfg_wdata[8:0];
                default: ;
            endcase
        end
    end

    // clamp depth and width to full scale
    logic [15:0] depth_c, width_c;
    assign depth_c = depth_reg[15] ? 16'd32768 : depth_reg;
    assign width_c = pan_width_reg[15] ? 16'd32768 : pan_width_reg;

    // sequencer: step counter within states
    dcsf_pkg::state_t state_reg, state_next;
    logic [3:0] step_reg;
    logic       clr_reg;
    logic [AW-1:0] clr_idx_reg;

    logic [AW-1:0] wr_idx_reg;
    logic [23:0]   ph_a_reg, ph_b_reg, ph_p_reg;
    logic signed [16:0] left_reg, right_reg;
    logic          last_reg;

    logic signed [15:0] sin_a_reg, sin_b_reg, sin_p_reg;
    logic [AW+7:0] dly_a_reg, dly_b_reg;
    logic signed [33:0] acc_reg;
    logic signed [24:0] tap_a_reg, tap_b_reg;
    logic signed [17:0] pan_l_reg;
    logic signed [23:0] wa_reg, wb_reg;

    // output register
    logic        out_valid_reg;
    logic [31:0] out_data_reg;
    logic        out_last_reg;

    // sine table
    logic [IW-1:0]      sin_idx;
    logic signed [15:0] sin_q;
    dcsf_sine #(.SINE_ENTRIES(SINE_ENTRIES)) u_sine (
        .aclk(aclk), .idx(sin_idx), .sin_q15(sin_q));

    // shared multiplier
    logic signed [24:0] op_a;
    logic signed [17:0] op_b;
    logic signed [42:0] prod;
    dcsf_mac u_mac (.aclk(aclk), .op_a(op_a), .op_b(op_b), .prod(prod));

    // delay line memories
    logic signed [23:0] mem_a [DELAY_DEPTH];
    logic signed [23:0] mem_b [DELAY_DEPTH];
    logic [AW-1:0] rd_addr;
    logic signed [23:0] rd_a, rd_b;
    logic mem_we;
    logic [AW-1:0] mem_waddr;
    logic signed [23:0] mem_wa, mem_wb;

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem_a[mem_waddr] <= mem_wa;
            mem_b[mem_waddr] <= mem_wb;
        end
        rd_a <= mem_a[rd_addr];
        rd_b <= mem_b[rd_addr];
    end

    assign mem_we    = clr_reg || (state_reg == dcsf_pkg::ST_WR);
    assign mem_waddr = clr_reg ? clr_idx_reg : wr_idx_reg;
    assign mem_wa    = clr_reg ? 24'sd0 : wa_reg;
    assign mem_wb    = clr_reg ? 24'sd0 : wb_reg;

    assign s_axis_tready = aresetn && !clr_reg && (state_reg == dcsf_pkg::ST_IDLE)
                           && (!out_valid_reg || m_axis_tready);
    wire in_xfer = s_axis_tvalid && s_axis_tready;

    // phase to table index
    always_comb begin
        priority case (1'b1)
            state_reg == dcsf_pkg::ST_SINA: sin_idx = ph_a_reg[23 -: IW];
            state_reg == dcsf_pkg::ST_SINB: sin_idx = ph_b_reg[23 -: IW];
            default:                        sin_idx = ph_p_reg[23 -: IW];
        endcase
    end

    // delay tap addresses: step 0/1 e0/e1 of line A, step 2/3 e0/e1 of line B
    logic [AW-1:0] di_a, di_b;
    assign di_a = dly_a_reg[AW+7:8];
    assign di_b = dly_b_reg[AW+7:8];
    always_comb begin
        unique case (step_reg)
            4'd0:    rd_addr = wr_idx_reg - di_a;
            4'd1:    rd_addr = wr_idx_reg - di_a - AW'(1);
            4'd2:    rd_addr = wr_idx_reg - di_b;
            default: rd_addr = wr_idx_reg - di_b - AW'(1);
        endcase
    end

    // the read data of A at step 0/1 and B at step 2/3 are captured
    logic signed [23:0] ea0_reg, ea1_reg, eb0_reg, eb1_reg;

    // multiplier operand selection
    logic [8:0] frac_a, frac_b;
    assign frac_a = {1'b0, dly_a_reg[7:0]};
    assign frac_b = {1'b0, dly_b_reg[7:0]};
    logic signed [17:0] pan_r;
    assign pan_r = 18'sd65536 - pan_l_reg;

    always_comb begin
        op_a = '0;
        op_b = '0;
        unique case (state_reg)
            dcsf_pkg::ST_DLYA: begin
                // step0: span*depth, step2: (that)*u
                if (step_reg == 4'd0) begin
                    op_a = 25'(sweep_span_reg); op_b = 18'(depth_c);
                end else begin
                    op_a = 25'(acc_reg); op_b = 18'(17'sd32768 + 17'(sin_a_reg));
                end
            end
            dcsf_pkg::ST_DLYB: begin
                if (step_reg == 4'd0) begin
                    op_a = 25'(sweep_span_reg); op_b = 18'(depth_c);
                end else begin
                    op_a = 25'(acc_reg); op_b = 18'(17'sd32768 + 17'(sin_b_reg));
                end
            end
            dcsf_pkg::ST_TAPA: begin
                unique case (step_reg)
                    4'd0:    begin op_a = 25'(ea0_reg); op_b = 18'(9'd256 - frac_a); end
                    default: begin op_a = 25'(ea1_reg); op_b = 18'(frac_a); end
                endcase
            end
            dcsf_pkg::ST_TAPB: begin
                unique case (step_reg)
                    4'd0:    begin op_a = 25'(eb0_reg); op_b = 18'(9'd256 - frac_b); end
                    default: begin op_a = 25'(eb1_reg); op_b = 18'(frac_b); end
                endcase
            end
            dcsf_pkg::ST_SINP: begin
                op_a = 25'(sin_p_reg); op_b = 18'(width_c);
            end
            dcsf_pkg::ST_MIX: begin
                unique case (step_reg)
                    4'd0:    begin op_a = tap_a_reg; op_b = pan_l_reg; end
                    4'd1:    begin op_a = tap_b_reg; op_b = pan_r; end
                    4'd2:    begin op_a = tap_a_reg; op_b = pan_r; end
                    4'd3:    begin op_a = tap_b_reg; op_b = pan_l_reg; end
                    4'd4:    begin op_a = tap_a_reg; op_b = 18'(feedback_reg); end
                    default: begin op_a = tap_b_reg; op_b = 18'(feedback_reg); end
                endcase
            end
            default: ;
        endcase
    end

    // saturation helpers
    function automatic logic signed [23:0] sat24(input logic signed [42:0] v);
        if (v > 43'sd8388607)       sat24 = 24'sh7FFFFF;
        else if (v < -43'sd8388608) sat24 = 24'sh800000;
        else                        sat24 = v[23:0];
    endfunction
    function automatic logic [15:0] sat16(input logic signed [42:0] v);
        if (v > 43'sd32767)       sat16 = 16'h7FFF;
        else if (v < -43'sd32768) sat16 = 16'h8000;
        else                      sat16 = v[15:0];
    endfunction

    logic signed [42:0] p_lr_reg;   // tapA*pan product, reused per channel (panL, then panR)
    logic signed [24:0] mono;
    assign mono = 25'(left_reg) + 25'(right_reg);

    // delay in Q.8 from the sweep product, clamped to the line
    logic [AW+8:0] dsum;
    always_comb begin
        dsum = (AW+9)'(base_delay_reg) * (AW+9)'(256) + (AW+9)'(prod >>> 23);
        if (dsum < (AW+9)'(256)) dsum = (AW+9)'(256);
        if (dsum > (AW+9)'(DMAX)) dsum = (AW+9)'(DMAX);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= dcsf_pkg::ST_IDLE;
            step_reg      <= '0;
            clr_reg       <= 1'b1;
            clr_idx_reg   <= '0;
            wr_idx_reg    <= '0;
            ph_a_reg      <= '0;
            ph_b_reg      <= dcsf_pkg::PHASE_B_RESET;
            ph_p_reg      <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            if (clr_reg) begin
                clr_idx_reg <= clr_idx_reg + AW'(1);
                if (clr_idx_reg == AW'(DELAY_DEPTH - 1)) clr_reg <= 1'b0;
            end
            if (out_valid_reg && m_axis_tready) out_valid_reg <= 1'b0;
            state_reg <= state_next;
            step_reg  <= (state_next != state_reg) ? 4'd0 : step_reg + 4'd1;

            unique case (state_reg)
                dcsf_pkg::ST_IDLE: ;
                dcsf_pkg::ST_SINA: if (step_reg == 4'd1) sin_a_reg <= sin_q;
                dcsf_pkg::ST_SINB: if (step_reg == 4'd1) sin_b_reg <= sin_q;
                dcsf_pkg::ST_SINP: begin
                    if (step_reg == 4'd1) sin_p_reg <= sin_q;
                    if (step_reg == 4'd3)
                        pan_l_reg <= 18'sd32768 + 18'(prod >>> 15);
                end
                dcsf_pkg::ST_DLYA, dcsf_pkg::ST_DLYB: begin
                    if (step_reg == 4'd1) acc_reg <= 34'(prod);
                    if (step_reg == 4'd3) begin
                        if (state_reg == dcsf_pkg::ST_DLYA) dly_a_reg <= dsum[AW+7:0];
                        else                                dly_b_reg <= dsum[AW+7:0];
                    end
                end
                dcsf_pkg::ST_RD: begin
                    if (step_reg == 4'd1) ea0_reg <= rd_a;
                    if (step_reg == 4'd2) ea1_reg <= rd_a;
                    if (step_reg == 4'd3) eb0_reg <= rd_b;
                    if (step_reg == 4'd4) eb1_reg <= rd_b;
                end
                dcsf_pkg::ST_TAPA: begin
                    if (step_reg == 4'd1) acc_reg <= 34'(prod);
                    if (step_reg == 4'd2) tap_a_reg <= 25'((acc_reg + 34'(prod)) >>> 8);
                end
                dcsf_pkg::ST_TAPB: begin
                    if (step_reg == 4'd1) acc_reg <= 34'(prod);
                    if (step_reg == 4'd2) tap_b_reg <= 25'((acc_reg + 34'(prod)) >>> 8);
                end
                dcsf_pkg::ST_MIX: begin
                    unique case (step_reg)
                        4'd1: p_lr_reg <= prod;
                        4'd2: out_data_reg[15:0] <= sat16(43'(left_reg)
                                  + ((p_lr_reg + prod) >>> 17));
                        4'd3: p_lr_reg <= prod;
                        4'd4: out_data_reg[31:16] <= sat16(43'(right_reg)
                                  + ((p_lr_reg + prod) >>> 17));
                        4'd5: wa_reg <= sat24(43'(mono) + (prod >>> 15));
                        4'd6: wb_reg <= sat24(43'(mono) + (prod >>> 15));
                        default: ;
                    endcase
                end
                dcsf_pkg::ST_WR: begin
                    wr_idx_reg    <= wr_idx_reg + AW'(1);
                    ph_a_reg      <= ph_a_reg + 24'(lfo_step_reg);
                    ph_b_reg      <= ph_b_reg + 24'(lfo_step_reg);
                    ph_p_reg      <= ph_p_reg + 24'(pan_step_reg);
                    out_valid_reg <= 1'b1;
                    out_last_reg  <= last_reg;
                end
                default: ;
            endcase

            if (in_xfer) begin
                left_reg  <= 17'(signed'(s_axis_tdata[15:0]));
                right_reg <= 17'(signed'(s_axis_tdata[31:16]));
                last_reg  <= s_axis_tlast;
            end
        end
    end

    // state transitions; RD issues addresses at steps 0..3, data arrive at the step after
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            dcsf_pkg::ST_IDLE: if (in_xfer) state_next = dcsf_pkg::ST_SINA;
            dcsf_pkg::ST_SINA: if (step_reg == 4'd1) state_next = dcsf_pkg::ST_SINB;
            dcsf_pkg::ST_SINB: if (step_reg == 4'd1) state_next = dcsf_pkg::ST_SINP;
            dcsf_pkg::ST_SINP: if (step_reg == 4'd3) state_next = dcsf_pkg::ST_DLYA;
            dcsf_pkg::ST_DLYA: if (step_reg == 4'd3) state_next = dcsf_pkg::ST_DLYB;
            dcsf_pkg::ST_DLYB: if (step_reg == 4'd3) state_next = dcsf_pkg::ST_RD;
            dcsf_pkg::ST_RD:   if (step_reg == 4'd4) state_next = dcsf_pkg::ST_TAPA;
            dcsf_pkg::ST_TAPA: if (step_reg == 4'd2) state_next = dcsf_pkg::ST_TAPB;
            dcsf_pkg::ST_TAPB: if (step_reg == 4'd2) state_next = dcsf_pkg::ST_MIX;
            dcsf_pkg::ST_MIX:  if (step_reg == 4'd6) state_next = dcsf_pkg::ST_WR;
            dcsf_pkg::ST_WR:   state_next = dcsf_pkg::ST_IDLE;
            default:           state_next = dcsf_pkg::ST_IDLE;
        endcase
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;
    assign m_axis_tlast  = out_last_reg;
endmodule
